// ===== rtl/suppression_release_sequencer_defines.svh =====
// Assertion helpers used by the sequencer RTL.
`ifndef SUPPRESSION_RELEASE_SEQUENCER_DEFINES_SVH
`define SUPPRESSION_RELEASE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clock, masked during reset.
`define SSQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, masked during reset.
`define SSQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ssq_pkg.sv =====
`default_nettype none
package ssq_pkg;

   // Parameter defaults
   localparam int RELAY_COUNT_DEFAULT      = 8;
   localparam int DEBOUNCE_TICKS_DEFAULT   = 50;
   localparam int TICKS_PER_SECOND_DEFAULT = 1000;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_WARNING_SECONDS    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_SECONDS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN_SECONDS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELAY_POLARITY_LOW = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOW_THRESHOLD     = 3'd4;

   localparam logic [15:0] WARNING_SECONDS_RESET  = 16'd10;
   localparam logic [15:0] RELEASE_SECONDS_RESET  = 16'd60;
   localparam logic [15:0] COOLDOWN_SECONDS_RESET = 16'd30;
   localparam logic        RELAY_POLARITY_RESET   = 1'b1;
   localparam logic [11:0] FLOW_THRESHOLD_RESET   = 12'd2000;

   // Phases
   localparam logic [1:0] PHASE_IDLE      = 2'd0;
   localparam logic [1:0] PHASE_WARNING   = 2'd1;
   localparam logic [1:0] PHASE_RELEASING = 2'd2;
   localparam logic [1:0] PHASE_COOLDOWN  = 2'd3;

   localparam logic [7:0]  ALL_ZONES     = 8'hFF;
   localparam logic [5:0]  PRESS_MAX     = 6'd63;
   localparam logic [15:0] SECONDS_MAX   = 16'hFFFF;

   typedef struct packed {
      logic [15:0] warning_seconds;
      logic [15:0] release_seconds;
      logic [15:0] cooldown_seconds;
      logic        relay_polarity_low;
      logic [11:0] flow_threshold;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  phase_code;
      logic [15:0] seconds_in_phase;
      logic [7:0]  armed_zones;
      logic        flow_flag;
      logic [5:0]  press_ticks;
   } state_type;

   typedef struct packed {
      logic        button_pressed;
      logic [11:0] flow_sample;
      logic        activate_request;
      logic [7:0]  activate_zones;
      logic        deactivate_request;
   } req_type;

   typedef struct packed {
      logic [7:0]  relay_pin_levels;
      logic [1:0]  phase;
      logic        flow_verified;
      logic [15:0] seconds_left;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/ssq_if.sv =====
`default_nettype none
interface ssq_req_if;
   logic        valid;
   logic        ready;
   logic        button_pressed;
   logic [11:0] flow_sample;
   logic        activate_request;
   logic [7:0]  activate_zones;
   logic        deactivate_request;

   modport source (output valid, button_pressed, flow_sample, activate_request,
                   activate_zones, deactivate_request, input ready);
   modport sink   (input valid, button_pressed, flow_sample, activate_request,
                   activate_zones, deactivate_request, output ready);
endinterface

interface ssq_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  relay_pin_levels;
   logic [1:0]  phase;
   logic        flow_verified;
   logic [15:0] seconds_left;

   modport source (output valid, relay_pin_levels, phase, flow_verified, seconds_left,
                   input ready);
   modport sink   (input valid, relay_pin_levels, phase, flow_verified, seconds_left,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/ssq_csr.sv =====
`default_nettype none
module ssq_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_en,
   input  wire logic [ssq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ssq_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output ssq_pkg::cfg_type                      cfg
);
   import ssq_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_WARNING_SECONDS:    cfg_in.warning_seconds    = csr_write_data;
            CSR_RELEASE_SECONDS:    cfg_in.release_seconds    = csr_write_data;
            CSR_COOLDOWN_SECONDS:   cfg_in.cooldown_seconds   = csr_write_data;
            CSR_RELAY_POLARITY_LOW: cfg_in.relay_polarity_low = csr_write_data[0];
            CSR_FLOW_THRESHOLD:     cfg_in.flow_threshold     = csr_write_data[11:0];
            default:                cfg_in                    = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warning_seconds    <= WARNING_SECONDS_RESET;
         cfg_ff.release_seconds    <= RELEASE_SECONDS_RESET;
         cfg_ff.cooldown_seconds   <= COOLDOWN_SECONDS_RESET;
         cfg_ff.relay_polarity_low <= RELAY_POLARITY_RESET;
         cfg_ff.flow_threshold     <= FLOW_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// ===== rtl/ssq_step.sv =====
`default_nettype none
module ssq_step #(
   parameter int RELAY_COUNT      = ssq_pkg::RELAY_COUNT_DEFAULT,
   parameter int DEBOUNCE_TICKS   = ssq_pkg::DEBOUNCE_TICKS_DEFAULT,
   parameter int TICKS_PER_SECOND = ssq_pkg::TICKS_PER_SECOND_DEFAULT,
   localparam int MS_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1
) (
   input  wire ssq_pkg::cfg_type    cfg,
   input  wire ssq_pkg::state_type  state_cur,
   input  wire logic [MS_W-1:0]     ms_cur,
   input  wire ssq_pkg::req_type    req,
   output ssq_pkg::state_type       state_nxt,
   output logic [MS_W-1:0]          ms_nxt,
   output ssq_pkg::rsp_type         rsp
);
   import ssq_pkg::*;

   localparam logic [7:0]  RELAY_MASK = 8'((1 << RELAY_COUNT) - 1);
   localparam logic [5:0]  DEBOUNCE   = 6'(DEBOUNCE_TICKS);
   localparam logic [MS_W:0] TPS      = (MS_W + 1)'(TICKS_PER_SECOND);

   state_type       st;
   logic [MS_W-1:0] ms;
   logic [MS_W:0]   ms_sum;
   logic [5:0]      press;
   logic [7:0]      on_mask;
   logic [15:0]     limit;

   always_comb begin
      st    = state_cur;
      ms    = ms_cur;
      press = '0;

      // deactivate, then activate
      if (req.deactivate_request) begin
         st.phase_code       = PHASE_IDLE;
         st.seconds_in_phase = '0;
         ms                  = '0;
      end
      if (req.activate_request && st.phase_code != PHASE_WARNING &&
          st.phase_code != PHASE_RELEASING) begin
         st.armed_zones      = req.activate_zones;
         st.phase_code       = PHASE_WARNING;
         st.seconds_in_phase = '0;
         ms                  = '0;
      end

      // timed update
      unique case (st.phase_code)
         PHASE_IDLE: begin
            if (req.button_pressed) begin
               press = (st.press_ticks != PRESS_MAX) ? st.press_ticks + 6'd1
                                                     : st.press_ticks;
               if (press >= DEBOUNCE) begin
                  st.press_ticks      = '0;
                  st.armed_zones      = ALL_ZONES;
                  st.phase_code       = PHASE_WARNING;
                  st.seconds_in_phase = '0;
                  ms                  = '0;
               end else begin
                  st.press_ticks = press;
               end
            end else begin
               st.press_ticks = '0;
            end
         end
         PHASE_WARNING: begin
            st.press_ticks = '0;
            if (st.seconds_in_phase >= cfg.warning_seconds) begin
               st.phase_code       = PHASE_RELEASING;
               st.seconds_in_phase = '0;
               ms                  = '0;
            end
         end
         PHASE_RELEASING: begin
            st.press_ticks = '0;
            st.flow_flag   = (req.flow_sample > cfg.flow_threshold);
            if (st.seconds_in_phase >= cfg.release_seconds) begin
               st.phase_code       = PHASE_COOLDOWN;
               st.seconds_in_phase = '0;
               ms                  = '0;
            end
         end
         default: begin
            st.press_ticks = '0;
            if (st.seconds_in_phase >= cfg.cooldown_seconds) begin
               st.phase_code       = PHASE_IDLE;
               st.seconds_in_phase = '0;
               ms                  = '0;
            end
         end
      endcase

      // result from the updated state
      on_mask = (st.phase_code == PHASE_RELEASING) ? (st.armed_zones & RELAY_MASK) : '0;
      rsp.relay_pin_levels = cfg.relay_polarity_low ? (~on_mask & RELAY_MASK) : on_mask;
      rsp.phase            = st.phase_code;
      rsp.flow_verified    = st.flow_flag;

      unique case (st.phase_code)
         PHASE_WARNING:   limit = cfg.warning_seconds;
         PHASE_RELEASING: limit = cfg.release_seconds;
         PHASE_COOLDOWN:  limit = cfg.cooldown_seconds;
         default:         limit = '0;
      endcase
      rsp.seconds_left = (limit > st.seconds_in_phase) ? limit - st.seconds_in_phase : '0;

      // advance the millisecond count
      ms_sum = {1'b0, ms} + (MS_W + 1)'(1);
      if (ms_sum >= TPS) begin
         ms = '0;
         if (st.seconds_in_phase != SECONDS_MAX) begin
            st.seconds_in_phase = st.seconds_in_phase + 16'd1;
         end
      end else begin
         ms = ms_sum[MS_W-1:0];
      end

      state_nxt = st;
      ms_nxt    = ms;
   end
endmodule
`default_nettype wire

// ===== rtl/suppression_release_sequencer.sv =====
// Suppression release sequencer.
//
// Each req beat is one millisecond tick carrying the button level, a flow
// sample and optional activate / deactivate requests; each tick yields exactly
// one rsp beat with the relay pin levels, phase, flow confirmation and the
// whole seconds left in the phase. Phases: idle, warning, releasing, cooldown.
// Write timing registers through the csr_ port only while idle (not enforced).
//
// A req beat accepted into the input register is evaluated in one pass and
// its result captured in the result register, which drives the rsp beat.
// Throughput: one beat per clock while rsp is not stalled; the single-pass
// next-state logic between the input register and the result register sets
// that figure. A stalled rsp holds its result register; the input register
// still takes one more beat, then req ready drops until the result is taken.
// Reset (synchronous, active high) restores register defaults, returns to
// idle with all counters and the zone mask cleared, and empties both stages.
`default_nettype none
`include "suppression_release_sequencer_defines.svh"
module suppression_release_sequencer #(
   parameter int RELAY_COUNT      = ssq_pkg::RELAY_COUNT_DEFAULT,
   parameter int DEBOUNCE_TICKS   = ssq_pkg::DEBOUNCE_TICKS_DEFAULT,
   parameter int TICKS_PER_SECOND = ssq_pkg::TICKS_PER_SECOND_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ssq_req_if.sink                              req_chan,
   ssq_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_write_en,
   input  wire logic [ssq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ssq_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import ssq_pkg::*;

   localparam int MS_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
   localparam logic [7:0] RELAY_MASK = 8'((1 << RELAY_COUNT) - 1);

   cfg_type         csr_cfg;

   // input stage
   logic            s1_valid_ff, s1_valid_in;
   req_type         s1_req_ff;

   // architectural state
   state_type       state_ff, state_in;
   logic [MS_W-1:0] ms_ff, ms_in;

   // result stage
   logic            rsp_valid_ff;
   rsp_type         rsp_ff, rsp_in;

   logic            req_accept;
   logic            rsp_adv;
   logic            s1_adv;

   ssq_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (csr_cfg)
   );

   ssq_step #(
      .RELAY_COUNT      (RELAY_COUNT),
      .DEBOUNCE_TICKS   (DEBOUNCE_TICKS),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_step (
      .cfg       (csr_cfg),
      .state_cur (state_ff),
      .ms_cur    (ms_ff),
      .req       (s1_req_ff),
      .state_nxt (state_in),
      .ms_nxt    (ms_in),
      .rsp       (rsp_in)
   );

   // Advance the tick when the result register is free or being drained.
   assign rsp_adv      = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv       = s1_valid_ff && rsp_adv;
   assign req_chan.ready = !s1_valid_ff || rsp_adv;
   assign req_accept   = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Capture the incoming beat; payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff.button_pressed     <= req_chan.button_pressed;
         s1_req_ff.flow_sample        <= req_chan.flow_sample;
         s1_req_ff.activate_request   <= req_chan.activate_request;
         s1_req_ff.activate_zones     <= req_chan.activate_zones;
         s1_req_ff.deactivate_request <= req_chan.deactivate_request;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // Commit the tick's state update together with its result.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         ms_ff        <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            state_ff     <= state_in;
            ms_ff        <= ms_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.relay_pin_levels = rsp_ff.relay_pin_levels;
   assign rsp_chan.phase            = rsp_ff.phase;
   assign rsp_chan.flow_verified    = rsp_ff.flow_verified;
   assign rsp_chan.seconds_left     = rsp_ff.seconds_left;

   `SSQ_ASSERT_NOW(a_idle_no_seconds,
                   rsp_valid_ff && rsp_ff.phase == PHASE_IDLE,
                   rsp_ff.seconds_left == 16'd0,
                   "seconds left nonzero in idle")
   `SSQ_ASSERT_NOW(a_relays_off_outside_release,
                   rsp_valid_ff && rsp_ff.phase != PHASE_RELEASING,
                   rsp_ff.relay_pin_levels ==
                      (csr_cfg.relay_polarity_low ? RELAY_MASK : 8'h00),
                   "relay engaged outside releasing")
   `SSQ_ASSERT_NOW(a_press_clear_outside_idle,
                   state_ff.phase_code != PHASE_IDLE,
                   state_ff.press_ticks == 6'd0,
                   "press count held outside idle")
   `SSQ_ASSERT_NEXT(a_deactivate_idles,
                    s1_adv && s1_req_ff.deactivate_request &&
                       !s1_req_ff.activate_request && !s1_req_ff.button_pressed,
                    state_ff.phase_code == PHASE_IDLE,
                    "deactivate did not return to idle")
endmodule
`default_nettype wire

// ===== bench/ssq_tick_checker.sv =====
`timescale 1ns / 100ps
module ssq_tick_checker
   import ssq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   ssq_req_if                     req_mon,
   ssq_rsp_if                     rsp_mon,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     fail_count,
   output int                     pending
);

   localparam int          TICKS_PER_S = TICKS_PER_SECOND_DEFAULT;
   localparam int          DEBOUNCE    = DEBOUNCE_TICKS_DEFAULT;
   localparam logic [7:0]  RELAY_MASK  = 8'((1 << RELAY_COUNT_DEFAULT) - 1);

   typedef struct packed {
      logic [1:0]  phase;
      logic [9:0]  ms;
      logic [15:0] secs;
      logic [7:0]  zones;
      logic        flow_ok;
      logic [5:0]  presses;
   } sequencer_state_type;

   cfg_type             cfg;
   sequencer_state_type tracked;
   rsp_type             due_results[$];
   rsp_type             want;
   rsp_type             got;
   req_type             tick;
   int                  errors;

   function automatic void enter_phase(input logic [1:0] ph);
      tracked.phase = ph;
      tracked.ms    = '0;
      tracked.secs  = '0;
   endfunction

   // Arming is ignored while warning or releasing; a cooldown restarts warning.
   function automatic void arm(input logic [7:0] mask);
      if (tracked.phase == PHASE_WARNING || tracked.phase == PHASE_RELEASING) return;
      tracked.zones = mask;
      enter_phase(PHASE_WARNING);
   endfunction

   function automatic logic [15:0] secs_left(input logic [15:0] limit);
      return (limit > tracked.secs) ? limit - tracked.secs : 16'd0;
   endfunction

   function automatic rsp_type predict_tick(input req_type t);
      rsp_type    r;
      logic [7:0] engaged;
      if (t.deactivate_request) enter_phase(PHASE_IDLE);
      if (t.activate_request) arm(t.activate_zones);

      case (tracked.phase)
         PHASE_IDLE: begin
            if (t.button_pressed) begin
               if (tracked.presses < PRESS_MAX) tracked.presses = tracked.presses + 6'd1;
               if (tracked.presses >= DEBOUNCE) begin
                  tracked.presses = '0;
                  arm(ALL_ZONES);
               end
            end else begin
               tracked.presses = '0;
            end
         end
         PHASE_WARNING: begin
            tracked.presses = '0;
            if (tracked.secs >= cfg.warning_seconds) enter_phase(PHASE_RELEASING);
         end
         PHASE_RELEASING: begin
            tracked.presses = '0;
            tracked.flow_ok = (t.flow_sample > cfg.flow_threshold);
            if (tracked.secs >= cfg.release_seconds) enter_phase(PHASE_COOLDOWN);
         end
         default: begin
            tracked.presses = '0;
            if (tracked.secs >= cfg.cooldown_seconds) enter_phase(PHASE_IDLE);
         end
      endcase

      engaged = (tracked.phase == PHASE_RELEASING) ? (tracked.zones & RELAY_MASK) : 8'd0;
      r.relay_pin_levels = cfg.relay_polarity_low ? (~engaged & RELAY_MASK) : engaged;
      r.phase            = tracked.phase;
      r.flow_verified    = tracked.flow_ok;
      case (tracked.phase)
         PHASE_WARNING:   r.seconds_left = secs_left(cfg.warning_seconds);
         PHASE_RELEASING: r.seconds_left = secs_left(cfg.release_seconds);
         PHASE_COOLDOWN:  r.seconds_left = secs_left(cfg.cooldown_seconds);
         default:         r.seconds_left = 16'd0;
      endcase

      // advance the millisecond clock; whole seconds saturate
      tracked.ms = tracked.ms + 10'd1;
      if (tracked.ms >= TICKS_PER_S) begin
         tracked.ms = '0;
         if (tracked.secs < SECONDS_MAX) tracked.secs = tracked.secs + 16'd1;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.warning_seconds    = WARNING_SECONDS_RESET;
         cfg.release_seconds    = RELEASE_SECONDS_RESET;
         cfg.cooldown_seconds   = COOLDOWN_SECONDS_RESET;
         cfg.relay_polarity_low = RELAY_POLARITY_RESET;
         cfg.flow_threshold     = FLOW_THRESHOLD_RESET;
         tracked       = '0;
         tracked.phase = PHASE_IDLE;
         due_results.delete();
         errors = 0;
      end else begin
         // compare the result beat first: it can never belong to this edge's request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.relay_pin_levels = rsp_mon.relay_pin_levels;
            got.phase            = rsp_mon.phase;
            got.flow_verified    = rsp_mon.flow_verified;
            got.seconds_left     = rsp_mon.seconds_left;
            if (due_results.size() == 0) begin
               $error("result beat arrived with no tick outstanding");
               errors++;
            end else begin
               want = due_results.pop_front();
               check_field("relay_pin_levels", 16'(want.relay_pin_levels),
                           16'(got.relay_pin_levels));
               check_field("phase", 16'(want.phase), 16'(got.phase));
               check_field("flow_verified", 16'(want.flow_verified),
                           16'(got.flow_verified));
               check_field("seconds_left", want.seconds_left, got.seconds_left);
            end
         end

         if (csr_write_en) begin
            case (csr_index)
               CSR_WARNING_SECONDS:    cfg.warning_seconds    = csr_write_data;
               CSR_RELEASE_SECONDS:    cfg.release_seconds    = csr_write_data;
               CSR_COOLDOWN_SECONDS:   cfg.cooldown_seconds   = csr_write_data;
               CSR_RELAY_POLARITY_LOW: cfg.relay_polarity_low = csr_write_data[0];
               CSR_FLOW_THRESHOLD:     cfg.flow_threshold     = csr_write_data[11:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            tick.button_pressed     = req_mon.button_pressed;
            tick.flow_sample        = req_mon.flow_sample;
            tick.activate_request   = req_mon.activate_request;
            tick.activate_zones     = req_mon.activate_zones;
            tick.deactivate_request = req_mon.deactivate_request;
            due_results.push_back(predict_tick(tick));
         end
      end
      fail_count <= errors;
      pending    <= due_results.size();
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
   import ssq_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int fail_count;
   int pending;
   int beats_sent;   // request beats accepted so far
   int steady_left;  // sender beats left in a gap-free stretch
   bit held_off;     // long receiver hold-off already done

   ssq_req_if req_chan();
   ssq_rsp_if rsp_chan();

   suppression_release_sequencer dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   ssq_tick_checker tick_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run, including the long hold-off.
   initial begin
      #1_000_000;
      $display("suppression_release_sequencer verification failed");
      $finish;
   end

   // Sender gap: mostly back to back, some short pauses, a few long ones,
   // and now and then a stretch with no pause at all.
   function automatic int pick_gap();
      int roll;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         steady_left = $urandom_range(30, 120);
         return 0;
      end
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one tick and hold it until accepted. Entered and left at a falling
   // edge, so valid is either kept high with new payload or dropped, never both.
   task automatic send_tick(input req_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.button_pressed     <= t.button_pressed;
      req_chan.flow_sample        <= t.flow_sample;
      req_chan.activate_request   <= t.activate_request;
      req_chan.activate_zones     <= t.activate_zones;
      req_chan.deactivate_request <= t.deactivate_request;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   function automatic req_type mk(input logic btn, input logic [11:0] flow, input logic act,
                                  input logic [7:0] zones, input logic drop);
      req_type t;
      t.button_pressed     = btn;
      t.flow_sample        = flow;
      t.activate_request   = act;
      t.activate_zones     = zones;
      t.deactivate_request = drop;
      return t;
   endfunction

   // A plain tick: no button, no requests; flow and zones still random.
   function automatic req_type quiet_tick();
      return mk(1'b0, 12'($urandom_range(0, 4095)), 1'b0, 8'($urandom_range(0, 255)), 1'b0);
   endfunction

   function automatic req_type noise_tick(input bit allow_drop);
      return mk(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                $urandom_range(0, 5) == 0, 8'($urandom_range(0, 255)),
                allow_drop && ($urandom_range(0, 11) == 0));
   endfunction

   // Drop valid, wait for every outstanding result, then let the pipe drain.
   task automatic settle();
      req_chan.valid <= 1'b0;
      wait (pending == 0);
      repeat (4) @(negedge clock);
   endtask

   // Write all five registers on consecutive cycles, then drop the enable.
   task automatic apply_settings(input logic [15:0] warn, input logic [15:0] rel,
                                 input logic [15:0] cool, input logic pol,
                                 input logic [11:0] thr);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_WARNING_SECONDS;
      csr_write_data <= warn;
      @(negedge clock);
      csr_index      <= CSR_RELEASE_SECONDS;
      csr_write_data <= rel;
      @(negedge clock);
      csr_index      <= CSR_COOLDOWN_SECONDS;
      csr_write_data <= cool;
      @(negedge clock);
      csr_index      <= CSR_RELAY_POLARITY_LOW;
      csr_write_data <= 16'(pol);
      @(negedge clock);
      csr_index      <= CSR_FLOW_THRESHOLD;
      csr_write_data <= 16'(thr);
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Random ticks built mostly from well-formed episodes: an activation
   // followed by a quiet run, a held button long enough (or nearly) to trip
   // the debounce, an occasional deactivate, and bursts of pure noise.
   task automatic random_run(input int budget, input int quiet_max, input bit allow_drop);
      int      issued;
      int      kind;
      int      len;
      req_type t;
      issued = 0;
      while (issued < budget) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            t = noise_tick(allow_drop);
            t.activate_request = 1'b1;
            send_tick(t);
            issued++;
            len = $urandom_range(5, quiet_max);
            repeat (len) begin
               send_tick(quiet_tick());
               issued++;
            end
         end else if (kind < 60) begin
            // hold the button; a rare release restarts the count
            len = $urandom_range(40, 60);
            repeat (len) begin
               t = quiet_tick();
               t.button_pressed = ($urandom_range(0, 59) != 0);
               send_tick(t);
               issued++;
            end
         end else if (kind < 68 && allow_drop) begin
            t = quiet_tick();
            t.deactivate_request = 1'b1;
            t.activate_request   = ($urandom_range(0, 3) == 0);
            send_tick(t);
            issued++;
         end else begin
            len = $urandom_range(1, 8);
            repeat (len) begin
               send_tick(noise_tick(allow_drop));
               issued++;
            end
         end
      end
   endtask

   // Result side: mostly ready, short stalls, a few long ones, calm stretches,
   // and one long hold-off while the sender keeps offering ticks so that the
   // block fills and drops req ready.
   initial begin : rsp_drain
      int stall;
      int calm;
      int roll;
      stall = 0;
      calm  = 0;
      held_off = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && beats_sent >= 400) begin
            held_off = 1'b1;
            stall    = 150;
         end else if (stall == 0 && calm == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 1) calm = $urandom_range(80, 200);
            else if (roll < 10) stall = $urandom_range(1, 3);
            else if (roll < 12) stall = $urandom_range(15, 40);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (calm > 0) calm--;
         end
      end
   end

   initial begin : stimulus
      reset                       = 1'b1;
      csr_write_en                = 1'b0;
      csr_index                   = CSR_WARNING_SECONDS;
      csr_write_data              = '0;
      req_chan.valid              = 1'b0;
      req_chan.button_pressed     = 1'b0;
      req_chan.flow_sample        = '0;
      req_chan.activate_request   = 1'b0;
      req_chan.activate_zones     = '0;
      req_chan.deactivate_request = 1'b0;
      beats_sent  = 0;
      steady_left = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: warning lasts ten seconds, so stay within it.
      send_tick(mk(1'b0, 12'd0, 1'b0, 8'h00, 1'b0));       // idle, nothing going on
      send_tick(mk(1'b0, 12'hFFF, 1'b0, 8'hFF, 1'b1));     // deactivate while idle
      send_tick(mk(1'b0, 12'd2000, 1'b1, 8'hA5, 1'b0));    // arm into warning
      send_tick(mk(1'b1, 12'd2001, 1'b1, 8'h5A, 1'b0));    // re-arm in warning is ignored
      send_tick(mk(1'b0, 12'd0, 1'b1, 8'hFF, 1'b1));       // deactivate, then arm, same tick
      send_tick(mk(1'b1, 12'hFFF, 1'b0, 8'h00, 1'b1));     // drop to idle, button counts

      // Zero warning falls straight into a releasing phase that never ends.
      settle();
      apply_settings(16'd0, SECONDS_MAX, 16'd0, 1'b0, 12'd0);
      send_tick(mk(1'b0, 12'd0, 1'b1, 8'h81, 1'b0));       // arm, relays engage at once
      send_tick(mk(1'b0, 12'd0, 1'b0, 8'h00, 1'b0));       // flow equal to threshold: no
      send_tick(mk(1'b0, 12'd1, 1'b0, 8'h00, 1'b0));       // flow just above: confirmed
      send_tick(mk(1'b1, 12'd0, 1'b1, 8'h7E, 1'b0));       // arm ignored while releasing
      send_tick(mk(1'b0, 12'hFFF, 1'b0, 8'h00, 1'b0));     // confirm again
      send_tick(mk(1'b0, 12'd0, 1'b0, 8'h00, 1'b1));       // deactivate keeps the flow flag

      // Zero release, endless cooldown, pins active low, top threshold.
      settle();
      apply_settings(16'd0, 16'd0, SECONDS_MAX, 1'b1, 12'hFFF);
      send_tick(mk(1'b0, 12'hFFF, 1'b1, 8'hC3, 1'b0));     // arm, straight to releasing
      send_tick(mk(1'b0, 12'hFFF, 1'b0, 8'h00, 1'b0));     // max flow not above max threshold
      send_tick(mk(1'b0, 12'hFFF, 1'b0, 8'h00, 1'b0));     // sitting in cooldown
      send_tick(mk(1'b0, 12'd0, 1'b1, 8'h3C, 1'b0));       // arm accepted from cooldown
      send_tick(mk(1'b0, 12'd100, 1'b0, 8'h00, 1'b1));     // drop

      // All phases zero length: fast cycling, plenty of debounce traffic.
      settle();
      apply_settings(16'd0, 16'd0, 16'd0, 1'b0, 12'd0);
      random_run(150, 40, 1'b1);

      // One-second releasing and cooldown: long quiet runs cross the second
      // boundary; no deactivates so the phases can run out.
      settle();
      apply_settings(16'd0, 16'd1, 16'd1, 1'($urandom_range(0, 1)),
                     12'($urandom_range(0, 4095)));
      send_tick(mk(1'b0, 12'($urandom_range(0, 4095)), 1'b1, 8'($urandom_range(0, 255)),
                   1'b0));
      random_run(1050, 300, 1'b0);

      // Every timer at its maximum.
      settle();
      apply_settings(SECONDS_MAX, SECONDS_MAX, SECONDS_MAX, 1'b1, 12'd2048);
      random_run(100, 30, 1'b1);

      // Short random timers and threshold.
      settle();
      apply_settings(16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                     16'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                     12'($urandom_range(0, 4095)));
      random_run(200, 60, 1'b1);

      settle();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("suppression_release_sequencer verification clean");
      end else begin
         $display("suppression_release_sequencer verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ssq_pkg.sv
rtl/ssq_if.sv
rtl/ssq_csr.sv
rtl/ssq_step.sv
rtl/suppression_release_sequencer.sv
bench/ssq_tick_checker.sv
bench/tb_top.sv
